// ===== sv/swag_pkg.sv =====
// Shared types and constants for the spectrum window average gate.
`default_nettype none

package swag_pkg;

  localparam int BIN_FW      = 6;
  localparam int MAG_W       = 32;
  localparam int LEVEL_W     = 8;
  localparam int AVG_SHIFT   = 3;
  localparam int LEVEL_SHIFT = 14;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;
  localparam int OUT_PAD_W   = OUT_DATA_W - BIN_FW - LEVEL_W;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_AVERAGE = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  typedef struct packed {
    logic fr_we;
    logic fr_re;
    logic nf_we;
    logic acc_clr;
    logic acc_add;
    logic out_load;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/swag_mem.sv =====
// Frame store and noise floor memories with registered read data.
`default_nettype none

module swag_mem #(
  parameter int BINS = 64,
  parameter int FRAMES = 8,
  localparam int DEPTH = BINS * FRAMES,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int BIN_W = $clog2(BINS)
) (
  input  wire logic                     clk_i,
  input  wire swag_pkg::ctl_t           ctl_i,
  input  wire logic [ADDR_W-1:0]        fr_waddr_i,
  input  wire logic [swag_pkg::MAG_W-1:0] fr_wdata_i,
  input  wire logic [ADDR_W-1:0]        fr_raddr_i,
  input  wire logic [BIN_W-1:0]         nf_waddr_i,
  input  wire logic [swag_pkg::MAG_W-1:0] nf_wdata_i,
  input  wire logic [BIN_W-1:0]         nf_raddr_i,
  output logic [swag_pkg::MAG_W-1:0]    fr_rdata_o,
  output logic [swag_pkg::MAG_W-1:0]    nf_rdata_o
);

  logic [swag_pkg::MAG_W-1:0] frame_mem [DEPTH];
  logic [swag_pkg::MAG_W-1:0] floor_mem [BINS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.fr_we) begin
      frame_mem[fr_waddr_i] <= fr_wdata_i;
    end
    if (ctl_i.fr_re) begin
      fr_rdata_o <= frame_mem[fr_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.nf_we) begin
      floor_mem[nf_waddr_i] <= nf_wdata_i;
    end
    if (ctl_i.fr_re) begin
      nf_rdata_o <= floor_mem[nf_raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/swag_acc.sv =====
// Shared accumulator, noise floor compare and result register.
`default_nettype none

module swag_acc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire swag_pkg::ctl_t                ctl_i,
  input  wire logic [swag_pkg::MAG_W-1:0]    fr_rdata_i,
  input  wire logic [swag_pkg::MAG_W-1:0]    nf_rdata_i,
  input  wire logic [swag_pkg::BIN_FW-1:0]   bin_i,
  input  wire logic                          out_ready_i,
  output logic [swag_pkg::MAG_W-1:0]         avg_o,
  output logic                               out_valid_o,
  output logic [swag_pkg::BIN_FW-1:0]        out_bin_o,
  output logic [swag_pkg::LEVEL_W-1:0]       level_o
);

  logic [swag_pkg::MAG_W-1:0]  sum_q, sum_d;
  logic [swag_pkg::LEVEL_W-1:0] level_d;
  logic                        out_valid_q, out_valid_d;
  logic [swag_pkg::BIN_FW-1:0]  out_bin_q;
  logic [swag_pkg::LEVEL_W-1:0] level_q;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.acc_clr) begin
      sum_d = '0;
    end else if (ctl_i.acc_add) begin
      sum_d = sum_q + fr_rdata_i;
    end
  end

  assign avg_o = sum_q >> swag_pkg::AVG_SHIFT;

  // An average equal to the floor is gated to zero.
  always_comb begin
    level_d = '0;
    if (avg_o > nf_rdata_i) begin
      level_d = avg_o[swag_pkg::LEVEL_SHIFT +: swag_pkg::LEVEL_W];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (ctl_i.out_load) begin
      out_bin_q <= bin_i;
      level_q   <= level_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bin_o   = out_bin_q;
  assign level_o     = level_q;

endmodule

`default_nettype wire

// ===== sv/swag_ctrl.sv =====
// Sequencer for the clearing sweep, store writes and per-bin average reads.
`default_nettype none

module swag_ctrl #(
  parameter int BINS = 64,
  parameter int FRAMES = 8,
  localparam int DEPTH = BINS * FRAMES,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int BIN_W = $clog2(BINS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [swag_pkg::BIN_FW-1:0]  bin_i,
  input  wire logic [swag_pkg::MAG_W-1:0]   mag_i,
  input  wire logic                         noise_i,
  input  wire logic                         out_busy_i,
  input  wire logic [swag_pkg::MAG_W-1:0]   avg_i,
  output swag_pkg::ctl_t                    ctl_o,
  output logic [ADDR_W-1:0]                 fr_waddr_o,
  output logic [swag_pkg::MAG_W-1:0]        fr_wdata_o,
  output logic [ADDR_W-1:0]                 fr_raddr_o,
  output logic [BIN_W-1:0]                  nf_waddr_o,
  output logic [swag_pkg::MAG_W-1:0]        nf_wdata_o,
  output logic [BIN_W-1:0]                  nf_raddr_o,
  output logic [swag_pkg::BIN_FW-1:0]       bin_o
);

  localparam int CNT_W = $clog2(FRAMES);
  localparam int CMP_W = ((BIN_W > swag_pkg::BIN_FW) ? BIN_W : swag_pkg::BIN_FW) + 1;
  localparam int LAST_BASE = (FRAMES - 1) * BINS;

  swag_pkg::state_e state_q, state_d;
  logic [ADDR_W-1:0]          clr_q, clr_d;
  logic [ADDR_W-1:0]          base_q, base_d;
  logic [ADDR_W-1:0]          rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       rd_vld_q;
  logic [swag_pkg::BIN_FW-1:0] bin_q;
  logic                       noise_q;
  logic                       accept;
  logic                       in_range;
  logic                       last_bin;
  logic                       is_avg;
  logic [BIN_W-1:0]           bin_a;

  assign accept   = in_valid_i && (state_q == swag_pkg::ST_IDLE);
  assign in_range = CMP_W'(bin_i) < CMP_W'(BINS);
  assign last_bin = CMP_W'(bin_i) == CMP_W'(BINS - 1);
  assign is_avg   = (swag_pkg::op_e'(op_i) == swag_pkg::OP_AVERAGE);
  assign bin_a    = BIN_W'(bin_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    base_d    = base_q;
    rd_addr_d = rd_addr_q;
    cnt_d     = cnt_q;
    ctl_o     = '0;
    ctl_o.acc_clr = accept;
    ctl_o.acc_add = rd_vld_q;
    case (state_q)
      swag_pkg::ST_CLEAR: begin
        ctl_o.fr_we = 1'b1;
        ctl_o.nf_we = clr_q < ADDR_W'(BINS);
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = swag_pkg::ST_IDLE;
        end
      end
      swag_pkg::ST_IDLE: begin
        if (accept && in_range) begin
          if (is_avg) begin
            rd_addr_d = ADDR_W'(bin_a);
            cnt_d     = '0;
            state_d   = swag_pkg::ST_READ;
          end else begin
            ctl_o.fr_we = 1'b1;
            if (last_bin) begin
              if (base_q == ADDR_W'(LAST_BASE)) begin
                base_d = '0;
              end else begin
                base_d = base_q + ADDR_W'(BINS);
              end
            end
          end
        end
      end
      swag_pkg::ST_READ: begin
        ctl_o.fr_re = 1'b1;
        rd_addr_d   = rd_addr_q + ADDR_W'(BINS);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAMES - 1)) begin
          state_d = swag_pkg::ST_DRAIN;
        end
      end
      swag_pkg::ST_DRAIN: begin
        state_d = swag_pkg::ST_FINISH;
      end
      swag_pkg::ST_FINISH: begin
        if (noise_q) begin
          ctl_o.nf_we = 1'b1;
          state_d = swag_pkg::ST_IDLE;
        end else if (!out_busy_i) begin
          ctl_o.out_load = 1'b1;
          state_d = swag_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swag_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swag_pkg::ST_CLEAR;
      clr_q    <= '0;
      base_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      base_q   <= base_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= ctl_o.fr_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    if (accept) begin
      bin_q   <= bin_i;
      noise_q <= noise_i;
    end
  end

  assign in_ready_o = (state_q == swag_pkg::ST_IDLE);
  assign fr_waddr_o = (state_q == swag_pkg::ST_CLEAR) ? clr_q : (base_q + ADDR_W'(bin_a));
  assign fr_wdata_o = (state_q == swag_pkg::ST_CLEAR) ? '0 : mag_i;
  assign fr_raddr_o = rd_addr_q;
  assign nf_waddr_o = (state_q == swag_pkg::ST_CLEAR) ? BIN_W'(clr_q) : BIN_W'(bin_q);
  assign nf_wdata_o = (state_q == swag_pkg::ST_CLEAR) ? '0 : avg_i;
  assign nf_raddr_o = BIN_W'(bin_q);
  assign bin_o      = bin_q;

endmodule

`default_nettype wire

// ===== sv/spectrum_window_average_gate.sv =====
// Top level of the spectrum window average gate.
//
// The input stream carries one request per transfer. A store request writes
// one bin magnitude into the current frame bank, and the bank advances
// after the last bin of a frame. An average request reads that bin from
// every frame bank, one frame store read per cycle, so it holds the input
// off while it passes through the read, drain and finish states. The
// result, if any, is loaded into the output register from the finish state.
// A noise phase average only updates the bin's noise floor and emits nothing.
// Otherwise one result is emitted: the bin and its gated level.
// After reset both memories are swept to zero, one frame store word per
// cycle; the input is not ready during the sweep. A stalled output holds
// its result in the output register, and the block keeps accepting
// requests; only a further result waits until that register is free.
`default_nettype none

module spectrum_window_average_gate #(
  parameter int BINS = 64,
  parameter int FRAMES = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: bin[5:0], magnitude[37:6], zero padding[39:38].
  input  wire logic [swag_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: opcode[0], noise_phase[1].
  input  wire logic [swag_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // Fields from bit 0: out_bin[5:0], level[13:6], zero padding[15:14].
  output logic [swag_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  localparam int DEPTH = BINS * FRAMES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W = $clog2(BINS);

  swag_pkg::ctl_t               ctl;
  logic [ADDR_W-1:0]            fr_waddr;
  logic [swag_pkg::MAG_W-1:0]   fr_wdata;
  logic [ADDR_W-1:0]            fr_raddr;
  logic [BIN_W-1:0]             nf_waddr;
  logic [swag_pkg::MAG_W-1:0]   nf_wdata;
  logic [BIN_W-1:0]             nf_raddr;
  logic [swag_pkg::MAG_W-1:0]   fr_rdata;
  logic [swag_pkg::MAG_W-1:0]   nf_rdata;
  logic [swag_pkg::MAG_W-1:0]   avg;
  logic [swag_pkg::BIN_FW-1:0]  bin_q;
  logic [swag_pkg::BIN_FW-1:0]  out_bin;
  logic [swag_pkg::LEVEL_W-1:0] level;
  logic                         out_busy;

  assign out_busy = m_axis_tvalid && !m_axis_tready;

  swag_ctrl #(
    .BINS   (BINS),
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser[0]),
    .bin_i      (s_axis_tdata[swag_pkg::BIN_FW-1:0]),
    .mag_i      (s_axis_tdata[swag_pkg::BIN_FW +: swag_pkg::MAG_W]),
    .noise_i    (s_axis_tuser[1]),
    .out_busy_i (out_busy),
    .avg_i      (avg),
    .ctl_o      (ctl),
    .fr_waddr_o (fr_waddr),
    .fr_wdata_o (fr_wdata),
    .fr_raddr_o (fr_raddr),
    .nf_waddr_o (nf_waddr),
    .nf_wdata_o (nf_wdata),
    .nf_raddr_o (nf_raddr),
    .bin_o      (bin_q)
  );

  swag_mem #(
    .BINS   (BINS),
    .FRAMES (FRAMES)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .fr_waddr_i (fr_waddr),
    .fr_wdata_i (fr_wdata),
    .fr_raddr_i (fr_raddr),
    .nf_waddr_i (nf_waddr),
    .nf_wdata_i (nf_wdata),
    .nf_raddr_i (nf_raddr),
    .fr_rdata_o (fr_rdata),
    .nf_rdata_o (nf_rdata)
  );

  swag_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .fr_rdata_i  (fr_rdata),
    .nf_rdata_i  (nf_rdata),
    .bin_i       (bin_q),
    .out_ready_i (m_axis_tready),
    .avg_o       (avg),
    .out_valid_o (m_axis_tvalid),
    .out_bin_o   (out_bin),
    .level_o     (level)
  );

  assign m_axis_tdata = {{swag_pkg::OUT_PAD_W{1'b0}}, level, out_bin};

endmodule

`default_nettype wire

// ===== sv/swag_chk.sv =====
// Port-level checker for the spectrum window average gate and its bind.
`default_nettype none

module swag_chk #(
  parameter int BINS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [swag_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [swag_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [swag_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic acc_avg;
  logic acc_store;

  assign acc_avg = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] &&
                   (32'(s_axis_tdata[swag_pkg::BIN_FW-1:0]) < 32'(BINS));
  assign acc_store = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input ready during clearing sweep");

  a_avg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_avg |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("average request did not hold off input");

  a_store_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_store |=> s_axis_tready)
    else $error("store request took more than one cycle");

endmodule

bind spectrum_window_average_gate swag_chk #(
  .BINS (BINS)
) u_swag_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
